// ----- src/etve_pkg.sv -----
// ----------------------------------------------------------------------------
// etve_pkg
// Shared types and constants for the eased tween value engine.
// ----------------------------------------------------------------------------
package etve_pkg;

    // Fraction bits of the progress and easing values.
    localparam int FRAC_BITS = 16;

    // Counter width of the iterative divider (one quotient bit a cycle).
    localparam int DIV_CNT_W = $clog2(FRAC_BITS);

    // Shared multiplier: signed 33-bit operand times unsigned FRAC_BITS+1 operand.
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = FRAC_BITS + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W + 1;

    // Input item operation codes.
    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_START  = 2'd1,
        OP_CANCEL = 2'd2
    } op_t;

    // Easing selector codes; the unused code behaves as ease-in-out.
    typedef enum logic [1:0] {
        EASE_LINEAR = 2'd0,
        EASE_OUT    = 2'd1,
        EASE_INOUT  = 2'd2
    } easing_t;

    // Configuration register indexes (byte address is four times the index).
    typedef enum logic [2:0] {
        REG_START_VALUE = 3'd0,
        REG_END_VALUE   = 3'd1,
        REG_DURATION    = 3'd2,
        REG_EASING      = 3'd3,
        REG_LOOP        = 3'd4,
        REG_ALTERNATE   = 3'd5
    } reg_idx_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_DIV,
        S_SQ,
        S_CUBE,
        S_EASE,
        S_LERP,
        S_SUM,
        S_FINISH
    } state_t;

endpackage

// ----- src/etve_div.sv -----
// ----------------------------------------------------------------------------
// etve_div
// Restoring divider that forms the progress fraction (dividend << FRAC_BITS)
// / divisor, one quotient bit a cycle. The dividend must be below the divisor.
// ----------------------------------------------------------------------------
module etve_div
    import etve_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [31:0]          dividend,
    input  logic [31:0]          divisor,
    output logic [FRAC_BITS-1:0] quotient,
    output logic                 done
);

    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic [31:0]          rem_reg;
    logic [31:0]          rem_next;
    logic [FRAC_BITS-1:0] quo_reg;
    logic [FRAC_BITS-1:0] quo_next;
    logic [32:0]          rem_shift;
    logic [32:0]          rem_sub;
    logic                 fits;

    // One trial subtraction of the doubled remainder.
    assign rem_shift = {rem_reg, 1'b0};
    assign rem_sub   = rem_shift - {1'b0, divisor};
    assign fits      = rem_shift >= {1'b0, divisor};

    // Step control and quotient shift.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(FRAC_BITS - 1);
            rem_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? rem_sub[31:0] : rem_shift[31:0];
            quo_next = {quo_reg[FRAC_BITS-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ----- src/eased_tween_value_engine.sv -----
// ----------------------------------------------------------------------------
// eased_tween_value_engine
// Single-slot tween engine: eased interpolation between two Q16.16 endpoints.
// ----------------------------------------------------------------------------
// Each input item carries an operation in s_tuser and a time stamp in s_tdata
// and produces exactly one result item. Start, cancel and ignored items, ticks
// while idle, and ticks at or past the end of the duration go from evaluation
// straight to the finish step, which presents their result. A tick inside the
// duration passes evaluation, the restoring divider that forms the progress
// fraction (FRAC_BITS quotient steps and its done flag), for the cubic curves
// the square and cube passes through the one shared 33 by 17 bit multiplier
// and the easing step, then the interpolation pass on that multiplier, a final
// add and the output load. The engine takes one item at a time; s_tready is
// high while it idles. A finished result waits in the output register; the
// next item is taken but holds in its finish step until that register is free.
// Configuration must be written through the APB port only while the engine
// idles; the block itself does not enforce this.
module eased_tween_value_engine
    import etve_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Input item stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] now_time
    input  logic [1:0]  s_tuser,    // [1:0] operation
    // Result item stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [31:0] value, [32] updated, [33] completed,
                                    // [34] running, [39:35] zero
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // Configuration registers.
    logic [31:0] start_value_reg;
    logic [31:0] end_value_reg;
    logic [31:0] duration_reg;
    logic [1:0]  easing_reg;
    logic        loop_reg;
    logic        alternate_reg;
    logic        cfg_write;
    logic [2:0]  cfg_index;

    // Tween state.
    logic        active_reg;
    logic        active_next;
    logic        first_seen_reg;
    logic        first_seen_next;
    logic        forward_reg;
    logic        forward_next;
    logic [31:0] begin_time_reg;
    logic [31:0] begin_time_next;

    // Sequencer and item registers.
    state_t      state_reg;
    state_t      state_next;
    logic [1:0]  op_reg;
    logic [31:0] now_reg;
    logic        at_end_reg;
    logic        half_reg;
    logic [FRAC_BITS:0] x_reg;
    logic [FRAC_BITS:0] e_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [31:0] lerp_value_reg;

    // Output register.
    logic        m_tvalid_reg;
    logic        m_tvalid_next;
    logic [39:0] m_tdata_reg;
    logic [39:0] m_tdata_next;

    // Combinational helpers.
    logic        in_accept;
    logic        out_free;
    logic [31:0] dur_w;
    logic [31:0] from_w;
    logic [31:0] to_w;
    logic [31:0] begin_w;
    logic [31:0] elapsed_w;
    logic        at_end_w;
    logic        tick_active_w;
    logic        div_start;
    logic        div_done;
    logic [FRAC_BITS-1:0] div_q;
    logic [FRAC_BITS:0]   p_w;
    logic [FRAC_BITS:0]   x_w;
    logic        half_w;
    logic [FRAC_BITS:0]   cube_w;
    logic [FRAC_BITS:0]   ease_w;
    logic signed [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0]        mul_b;
    logic signed [PROD_W-1:0]  prod_w;
    logic signed [PROD_W-1:0]  delta_w;
    logic signed [MUL_A_W-1:0] diff_w;
    logic        out_updated;
    logic        out_completed;
    logic [31:0] out_value;

    // ------------------------------------------------------------------
    // Configuration port.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_value_reg <= '0;
            end_value_reg   <= '0;
            duration_reg    <= 32'd1;
            easing_reg      <= EASE_LINEAR;
            loop_reg        <= 1'b0;
            alternate_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_START_VALUE: start_value_reg <= pwdata;
                REG_END_VALUE:   end_value_reg   <= pwdata;
                REG_DURATION:    duration_reg    <= pwdata;
                REG_EASING:      easing_reg      <= pwdata[1:0];
                REG_LOOP:        loop_reg        <= pwdata[0];
                REG_ALTERNATE:   alternate_reg   <= pwdata[0];
                default:         ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (cfg_index)
            REG_START_VALUE: prdata = start_value_reg;
            REG_END_VALUE:   prdata = end_value_reg;
            REG_DURATION:    prdata = duration_reg;
            REG_EASING:      prdata = {30'd0, easing_reg};
            REG_LOOP:        prdata = {31'd0, loop_reg};
            REG_ALTERNATE:   prdata = {31'd0, alternate_reg};
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Timing and endpoints.
    // ------------------------------------------------------------------
    assign in_accept     = s_tvalid && s_tready;
    assign out_free      = !m_tvalid_reg || m_tready;
    assign dur_w         = (duration_reg == '0) ? 32'd1 : duration_reg;
    assign from_w        = forward_reg ? start_value_reg : end_value_reg;
    assign to_w          = forward_reg ? end_value_reg : start_value_reg;
    assign begin_w       = first_seen_reg ? begin_time_reg : now_reg;
    assign elapsed_w     = now_reg - begin_w;
    assign at_end_w      = elapsed_w >= dur_w;
    assign tick_active_w = (op_reg == OP_TICK) && active_reg;
    assign diff_w        = $signed({to_w[31], to_w}) - $signed({from_w[31], from_w});

    // Progress fraction divider.
    etve_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (elapsed_w),
        .divisor  (dur_w),
        .quotient (div_q),
        .done     (div_done)
    );

    // Easing operand from the progress fraction.
    assign p_w    = {1'b0, div_q};
    assign half_w = !div_q[FRAC_BITS-1];

    always_comb
    begin
        case (easing_reg)
            EASE_LINEAR: x_w = p_w;
            EASE_OUT:    x_w = ONE - p_w;
            default:     x_w = half_w ? p_w : (FRAC_BITS+1)'((ONE - p_w) << 1);
        endcase
    end

    // Easing result from the truncated cube (the operand itself for linear easing).
    assign cube_w = prod_reg[FRAC_BITS +: FRAC_BITS+1];

    always_comb
    begin
        case (easing_reg)
            EASE_LINEAR: ease_w = x_reg;
            EASE_OUT:    ease_w = ONE - cube_w;
            default:     ease_w = half_reg ? (FRAC_BITS+1)'(cube_w << 2)
                                           : ONE - (cube_w >> 1);
        endcase
    end

    // ------------------------------------------------------------------
    // Shared multiplier, one use per sequencer step.
    // ------------------------------------------------------------------
    always_comb
    begin
        case (state_reg)
            S_SQ:
            begin
                mul_a = $signed({{(MUL_A_W-FRAC_BITS-1){1'b0}}, x_reg});
                mul_b = x_reg;
            end
            S_CUBE:
            begin
                mul_a = $signed({{(MUL_A_W-FRAC_BITS-1){1'b0}}, cube_w});
                mul_b = x_reg;
            end
            default:
            begin
                mul_a = diff_w;
                mul_b = e_reg;
            end
        endcase
    end

    assign prod_w  = mul_a * $signed({1'b0, mul_b});
    assign delta_w = prod_reg >>> FRAC_BITS;

    // ------------------------------------------------------------------
    // Sequencer next state.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_accept)
                begin
                    state_next = S_EVAL;
                end
            S_EVAL:
                state_next = (tick_active_w && !at_end_w) ? S_DIV : S_FINISH;
            S_DIV:
                if (div_done)
                begin
                    state_next = (easing_reg == EASE_LINEAR) ? S_LERP : S_SQ;
                end
            S_SQ:     state_next = S_CUBE;
            S_CUBE:   state_next = S_EASE;
            S_EASE:   state_next = S_LERP;
            S_LERP:   state_next = S_SUM;
            S_SUM:    state_next = S_FINISH;
            S_FINISH:
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            default:  state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer outputs.
    // ------------------------------------------------------------------
    always_comb
    begin
        s_tready  = (state_reg == S_IDLE);
        div_start = (state_reg == S_EVAL) && tick_active_w && !at_end_w;
    end

    // Result fields and state update when the result is issued.
    always_comb
    begin
        active_next     = active_reg;
        first_seen_next = first_seen_reg;
        forward_next    = forward_reg;
        begin_time_next = begin_time_reg;
        out_value       = '0;
        out_updated     = 1'b0;
        out_completed   = 1'b0;
        case (op_reg)
            OP_START:
            begin
                active_next     = 1'b1;
                first_seen_next = 1'b0;
                forward_next    = 1'b1;
            end
            OP_CANCEL:
                active_next = 1'b0;
            OP_TICK:
                if (active_reg)
                begin
                    out_updated     = 1'b1;
                    first_seen_next = 1'b1;
                    begin_time_next = begin_w;
                    out_value       = lerp_value_reg;
                    if (at_end_reg)
                    begin
                        out_value = to_w;
                        if (loop_reg)
                        begin
                            begin_time_next = now_reg;
                            if (alternate_reg)
                            begin
                                forward_next = !forward_reg;
                            end
                        end
                        else
                        begin
                            active_next   = 1'b0;
                            out_completed = 1'b1;
                        end
                    end
                end
            default: ;
        endcase
    end

    // Output register loading.
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        if ((state_reg == S_FINISH) && out_free)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {5'd0, active_next, out_completed, out_updated, out_value};
        end
    end

    // ------------------------------------------------------------------
    // Control registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            m_tvalid_reg   <= 1'b0;
            active_reg     <= 1'b0;
            first_seen_reg <= 1'b0;
            forward_reg    <= 1'b1;
            begin_time_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if ((state_reg == S_FINISH) && out_free)
            begin
                active_reg     <= active_next;
                first_seen_reg <= first_seen_next;
                forward_reg    <= forward_next;
                begin_time_reg <= begin_time_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        if (in_accept)
        begin
            op_reg  <= s_tuser;
            now_reg <= s_tdata;
        end
        if (state_reg == S_EVAL)
        begin
            at_end_reg <= at_end_w;
        end
        if ((state_reg == S_DIV) && div_done)
        begin
            x_reg    <= x_w;
            half_reg <= half_w;
            e_reg    <= p_w;
        end
        if (state_reg == S_EASE)
        begin
            e_reg <= ease_w;
        end
        if ((state_reg == S_SQ) || (state_reg == S_CUBE) || (state_reg == S_LERP))
        begin
            prod_reg <= prod_w;
        end
        if (state_reg == S_SUM)
        begin
            lerp_value_reg <= from_w + delta_w[31:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTH
    // An accepted item always starts with the evaluation step.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == S_EVAL))
        else $error("accepted item did not enter evaluation");

    // The divider only reports completion while the sequencer waits on it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide step");

    // The eased fraction never exceeds one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LERP) |-> (e_reg <= ONE))
        else $error("eased fraction above one");

    // A completion flag comes with an update and a stopped tween.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && m_tdata_reg[33]) |-> (m_tdata_reg[32] && !m_tdata_reg[34]))
        else $error("completed result with inconsistent flags");
`endif

endmodule

// ----- tb/sv/testbench.sv -----
// ============================================================================
// Testbench for the eased tween value engine
// Drives start, cancel, tick and ignored items into the input stream. Each
// accepted item is run through a behavioral model of the tween slot, and
// every result item is checked field by field against the oldest expected
// result. Directed items cover the control operations and each easing curve.
// Random tweens follow with random endpoints, durations, easing and looping,
// under several patterns of sender gaps and receiver stalls.
// ============================================================================
module testbench;
    import etve_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Operation code that the engine ignores.
    localparam logic [1:0] OP_IGNORED = 2'd3;

    localparam longint unsigned Q_ONE = 64'd1 << FRAC_BITS;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    // One result item, split into its fields.
    typedef struct packed {
        logic [31:0] value;
        logic        updated;
        logic        completed;
        logic        running;
    } tween_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;    // [31:0] now_time
    logic [1:0]  s_tuser;    // [1:0] operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;    // [31:0] value, [32] updated, [33] completed,
                             // [34] running, [39:35] zero
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Configuration as seen by the model.
    logic [31:0] cfg_start;
    logic [31:0] cfg_end;
    logic [31:0] cfg_duration;
    logic [1:0]  cfg_easing;
    logic        cfg_loop;
    logic        cfg_alternate;

    // Tween slot state of the model.
    logic        tw_active;
    logic        tw_started;
    logic        tw_forward;
    logic [31:0] tw_begin;

    tween_result_t tween_expect_q[$];
    int unsigned   error_count = 0;
    int unsigned   items_sent = 0;
    int unsigned   cycle_count = 0;
    int unsigned   send_gap_pct = 0;
    int unsigned   stall_pct = 0;
    int unsigned   hold_serial = 0;
    int unsigned   hold_serial_seen = 0;
    int unsigned   hold_left = 0;

    eased_tween_value_engine dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Free-running clock with a 2 ns period.
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Abort the run if it takes far longer than the slowest correct run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Cubes a Q1.F fraction, truncating after each multiply.
    function automatic longint unsigned cube_frac(longint unsigned x);
        longint unsigned sq;
        sq = (x * x) >> FRAC_BITS;
        return (sq * x) >> FRAC_BITS;
    endfunction

    // Applies the selected easing curve to the progress fraction.
    function automatic longint unsigned shape_progress(longint unsigned p);
        case (cfg_easing)
            EASE_LINEAR: return p;
            EASE_OUT:    return Q_ONE - cube_frac(Q_ONE - p);
            default:
            begin
                if (p < (Q_ONE >> 1))
                    return cube_frac(p) << 2;
                return Q_ONE - (cube_frac((Q_ONE - p) << 1) >> 1);
            end
        endcase
    endfunction

    // Interpolates between two signed Q16.16 endpoints, rounding toward minus infinity.
    function automatic logic [31:0] interpolate(logic [31:0] src_val, logic [31:0] dst_val,
                                                longint unsigned e);
        longint base;
        longint diff;
        longint prod;
        base = longint'(signed'(src_val));
        diff = longint'(signed'(dst_val)) - base;
        prod = diff * longint'(e);
        return 32'(base + (prod >>> FRAC_BITS));
    endfunction

    // Advances the tween slot by one accepted item and returns its result.
    function automatic tween_result_t advance_tween(logic [1:0] op, logic [31:0] tick_time);
        tween_result_t   r;
        logic [31:0]     dur;
        logic [31:0]     src_val;
        logic [31:0]     dst_val;
        logic [31:0]     elapsed;
        longint unsigned p;
        r = '0;
        if (op == OP_START)
        begin
            tw_active  = 1'b1;
            tw_started = 1'b0;
            tw_forward = 1'b1;
        end
        else if (op == OP_CANCEL)
        begin
            tw_active = 1'b0;
        end
        else if (op == OP_TICK && tw_active)
        begin
            dur     = (cfg_duration == 32'd0) ? 32'd1 : cfg_duration;
            src_val = tw_forward ? cfg_start : cfg_end;
            dst_val = tw_forward ? cfg_end : cfg_start;
            if (!tw_started)
            begin
                tw_begin   = tick_time;
                tw_started = 1'b1;
            end
            elapsed   = tick_time - tw_begin;
            r.updated = 1'b1;
            if (elapsed < dur)
            begin
                p       = (64'(elapsed) << FRAC_BITS) / 64'(dur);
                r.value = interpolate(src_val, dst_val, shape_progress(p));
            end
            else
            begin
                // The end of the duration: emit the exact endpoint, then loop or finish.
                r.value = dst_val;
                if (cfg_loop)
                begin
                    if (cfg_alternate)
                        tw_forward = !tw_forward;
                    tw_begin = tick_time;
                end
                else
                begin
                    tw_active   = 1'b0;
                    r.completed = 1'b1;
                end
            end
        end
        r.running = tw_active;
        return r;
    endfunction

    // Receiver ready: a long hold-off on request, otherwise random stalls.
    always @(posedge clk)
    begin
        if (hold_serial != hold_serial_seen)
        begin
            hold_serial_seen = hold_serial;
            hold_left        = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Compare every accepted result item with the oldest expected result.
    always @(posedge clk)
    begin : result_check
        tween_result_t want;
        tween_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.value     = m_tdata[31:0];
            got.updated   = m_tdata[32];
            got.completed = m_tdata[33];
            got.running   = m_tdata[34];
            if (tween_expect_q.size() == 0)
            begin
                $error("result item with no expected result: %h", m_tdata);
                error_count++;
            end
            else
            begin
                want = tween_expect_q.pop_front();
                if (got.value !== want.value)
                begin
                    $error("value: expected %h, got %h", want.value, got.value);
                    error_count++;
                end
                if (got.updated !== want.updated)
                begin
                    $error("updated: expected %b, got %b", want.updated, got.updated);
                    error_count++;
                end
                if (got.completed !== want.completed)
                begin
                    $error("completed: expected %b, got %b", want.completed, got.completed);
                    error_count++;
                end
                if (got.running !== want.running)
                begin
                    $error("running: expected %b, got %b", want.running, got.running);
                    error_count++;
                end
            end
        end
    end

    // Offers one item after random idle cycles and records its expected result.
    // Valid stays high afterwards so that back-to-back items need no gap.
    task automatic send_item(logic [1:0] op, logic [31:0] tick_time);
        tween_result_t expected;
        while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= tick_time;
        do
            @(posedge clk);
        while (!s_tready);
        expected       = advance_tween(op, tick_time);
        tween_expect_q = {tween_expect_q, expected};
        items_sent++;
    endtask

    // Stops offering items and waits until every expected result has arrived.
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (tween_expect_q.size() != 0);
    endtask

    // Writes one configuration register through the APB port.
    task automatic write_register(reg_idx_t idx, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_START_VALUE: cfg_start     = data;
            REG_END_VALUE:   cfg_end       = data;
            REG_DURATION:    cfg_duration  = data;
            REG_EASING:      cfg_easing    = data[1:0];
            REG_LOOP:        cfg_loop      = data[0];
            REG_ALTERNATE:   cfg_alternate = data[0];
            default: ;
        endcase
    endtask

    // Writes the whole register set; the engine must be idle.
    task automatic set_config(logic [31:0] start_val, logic [31:0] end_val,
                              logic [31:0] dur, logic [1:0] easing,
                              logic loop_on, logic alt_on);
        write_register(REG_START_VALUE, start_val);
        write_register(REG_END_VALUE, end_val);
        write_register(REG_DURATION, dur);
        write_register(REG_EASING, {30'd0, easing});
        write_register(REG_LOOP, {31'd0, loop_on});
        write_register(REG_ALTERNATE, {31'd0, alt_on});
    endtask

    task automatic set_idling(int unsigned gap_pct, int unsigned stall_rate);
        send_gap_pct = gap_pct;
        stall_pct    = stall_rate;
    endtask

    // Picks random endpoints, duration, easing and looping.
    task automatic randomize_config();
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] d;
        case ($urandom_range(5))
            0:
            begin
                a = 32'h8000_0000;
                b = 32'h7FFF_FFFF;
            end
            1:
            begin
                a = 32'h7FFF_FFFF;
                b = 32'h8000_0000;
            end
            2:
            begin
                a = $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
                b = $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
            end
            3:
            begin
                a = $urandom;
                b = a;
            end
            4:
            begin
                a = $urandom;
                b = a + $urandom_range(0, 255) - 32'd128;
            end
            default:
            begin
                a = $urandom;
                b = $urandom;
            end
        endcase
        case ($urandom_range(9))
            0:       d = 32'd0;
            1:       d = 32'd1;
            2:       d = 32'hFFFF_FFFF;
            3:       d = $urandom;
            default: d = $urandom_range(2, 48);
        endcase
        set_config(a, b, d, 2'($urandom_range(3)), 1'($urandom_range(1)),
                   1'($urandom_range(1)));
    endtask

    // A tween run: a start item, then ticks with rising time and some noise.
    task automatic run_tween_sequence(int unsigned n_items);
        logic [31:0] tick_time;
        logic [31:0] dur;
        logic [31:0] advance;
        int unsigned k;
        dur = (cfg_duration == 32'd0) ? 32'd1 : cfg_duration;
        if ($urandom_range(5) == 0)
            tick_time = 32'hFFFF_FFFF - $urandom_range(0, 64);
        else
            tick_time = $urandom;
        send_item(OP_START, $urandom);
        for (k = 1; k < n_items; k++)
        begin
            case ($urandom_range(19))
                0: send_item(OP_CANCEL, $urandom);
                1: send_item(OP_IGNORED, $urandom);
                2: send_item(OP_START, $urandom);
                3:
                begin
                    // Time stepping backwards wraps to a large elapsed time.
                    tick_time = tick_time - $urandom_range(1, 16);
                    send_item(OP_TICK, tick_time);
                end
                4:
                begin
                    tick_time = tick_time + $urandom;
                    send_item(OP_TICK, tick_time);
                end
                default:
                begin
                    if (!tw_active && $urandom_range(3) != 0)
                    begin
                        send_item(OP_START, $urandom);
                    end
                    else
                    begin
                        if (dur <= 32'd64)
                            advance = $urandom_range(0, dur / 3 + 1);
                        else
                            advance = $urandom_range(0, dur / 4);
                        tick_time = tick_time + advance;
                        send_item(OP_TICK, tick_time);
                    end
                end
            endcase
        end
    endtask

    // Control items while idle and while running, the shortest duration and
    // the widest span between the endpoints.
    task automatic test_control_items();
        set_idling(0, 0);
        set_config(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, EASE_LINEAR, 1'b0, 1'b0);
        send_item(OP_TICK, 32'hFFFF_FFFF);
        send_item(OP_CANCEL, 32'd0);
        send_item(OP_IGNORED, 32'h5555_AAAA);
        send_item(OP_START, 32'hAAAA_5555);
        send_item(OP_IGNORED, 32'd0);
        send_item(OP_TICK, 32'd0);
        send_item(OP_TICK, 32'd1);
        send_item(OP_TICK, 32'd2);
        send_item(OP_START, 32'd0);
        send_item(OP_TICK, 32'd5);
        send_item(OP_START, 32'd0);
        send_item(OP_CANCEL, 32'd0);
        send_item(OP_TICK, 32'd6);
        wait_results_drained();
    endtask

    // Each easing selector at three quarters of the way, then a looping
    // reversal with the unused selector.
    task automatic test_easing_curves();
        int unsigned e;
        set_idling(0, 0);
        for (e = 0; e < 4; e++)
        begin
            set_config(32'h7FFF_FFFF, 32'h8000_0000, 32'd4, 2'(e), 1'b1, 1'b1);
            send_item(OP_START, 32'd0);
            send_item(OP_TICK, 32'd100);
            send_item(OP_TICK, 32'd103);
            wait_results_drained();
        end
        send_item(OP_TICK, 32'd104);
        send_item(OP_TICK, 32'd105);
        wait_results_drained();
    endtask

    // Random tweens under one pattern of sender gaps and receiver stalls.
    task automatic test_random_tweens(int unsigned gap_pct, int unsigned stall_rate,
                                      int unsigned target);
        int unsigned goal;
        set_idling(gap_pct, stall_rate);
        goal = items_sent + target;
        while (items_sent < goal)
        begin
            wait_results_drained();
            randomize_config();
            run_tween_sequence($urandom_range(8, 40));
        end
        wait_results_drained();
    endtask

    // The receiver holds off for a long stretch while items keep coming, so
    // the output register fills and the engine stops taking input.
    task automatic test_output_backpressure();
        logic [31:0] tick_time;
        int unsigned k;
        set_idling(0, 0);
        set_config(32'h0001_0000, 32'hFFF0_0000, 32'd7, EASE_OUT, 1'b1, 1'b1);
        hold_serial++;
        tick_time = 32'hFFFF_FFF0;
        send_item(OP_START, 32'd0);
        for (k = 0; k < 30; k++)
        begin
            tick_time = tick_time + $urandom_range(0, 3);
            send_item(OP_TICK, tick_time);
        end
        wait_results_drained();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        cfg_start     = '0;
        cfg_end       = '0;
        cfg_duration  = 32'd1;
        cfg_easing    = EASE_LINEAR;
        cfg_loop      = 1'b0;
        cfg_alternate = 1'b0;
        tw_active     = 1'b0;
        tw_started    = 1'b0;
        tw_forward    = 1'b1;
        tw_begin      = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_control_items();
        test_easing_curves();
        test_random_tweens(0, 0, 260);
        test_random_tweens(57, 0, 260);
        test_output_backpressure();
        test_random_tweens(0, 57, 260);
        test_random_tweens(10, 10, 260);

        // Let any stray result item show up before the verdict.
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tween_expect_q.size() != 0)
        begin
            $error("%0d expected results never arrived", tween_expect_q.size());
            error_count++;
        end
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- sim.f -----
src/etve_pkg.sv
src/etve_div.sv
src/eased_tween_value_engine.sv
tb/sv/testbench.sv
